// ===== design/text_console_scroll_writer_core_defines.svh =====
// Assertion macros shared by the text console scroll writer RTL.
`ifndef TEXT_CONSOLE_SCROLL_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_SCROLL_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// ante true at an edge implies cons at the same edge
`define TCSW_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcsw: same-cycle check failed");

// ante true at an edge implies cons at the next edge
`define TCSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcsw: next-cycle check failed");

`else

`define TCSW_ASSERT_IMPLIES(label, ante, cons)
`define TCSW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/tcsw_pkg.sv =====
// Types and constants for the text console scroll writer.
`timescale 1ns / 1ps

package tcsw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int OUTP_W = 11;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int POS_W  = $clog2(CELL_COUNT + 1);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CH_W   = 7;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_MASK    = 8'h7F;
  localparam logic [7:0]        ATTR_WHITE   = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LEN  = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

  typedef enum logic [2:0] {
    OP_PUT_CHAR,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  ch;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_WRITE,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

// ===== design/tcsw_front.sv =====
// Front end: takes input transactions and classifies them into commands.
`timescale 1ns / 1ps

module tcsw_front (
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [tcsw_pkg::MODE_W-1:0]   mode,
  input  logic [tcsw_pkg::CHAR_W-1:0]   character,
  input  logic [tcsw_pkg::IDX_W-1:0]    cell_index,
  input  logic                          q_full,
  output tcsw_pkg::push_t               q_push
);
  import tcsw_pkg::*;

  cmd_t cmd;

  always_comb begin
    cmd.ch   = CH_W'(character & CHAR_MASK);
    cmd.addr = ADDR_W'(cell_index);
    unique case (mode)
      MODE_PUT: begin
        cmd.op = (character == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT_CHAR;
      end
      MODE_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      MODE_READ: begin
        cmd.op = (cell_index < IDX_W'(CELL_COUNT)) ? OP_READ : OP_NOP;
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

  assign cmd_stall   = q_full;
  assign q_push.push = cmd_valid && !q_full;
  assign q_push.cmd  = cmd;

endmodule

// ===== design/tcsw_queue.sv =====
// Short command queue between the front end and the executor.
`timescale 1ns / 1ps

module tcsw_queue (
  input  logic             clk,
  input  logic             rst,
  input  tcsw_pkg::push_t  q_push,
  output logic             q_full,
  input  logic             q_pop,
  output logic             q_valid,
  output tcsw_pkg::cmd_t   q_cmd
);
  import tcsw_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];
  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.cmd;
    end
  end

endmodule

// ===== design/tcsw_back.sv =====
// Executor: cell store, cursor, scroll and clear sequencer, result register.
`timescale 1ns / 1ps
`include "text_console_scroll_writer_core_defines.svh"

module tcsw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tcsw_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [tcsw_pkg::CELL_W-1:0]   cell_data,
  output logic [tcsw_pkg::OUTP_W-1:0]   cursor_position
);
  import tcsw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  state_t            state, state_next;
  logic [ADDR_W-1:0] sweep, sweep_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  logic [POS_W-1:0]  row_start, row_start_next;
  logic [COL_W-1:0]  col, col_next;
  cmd_t              cmd, cmd_next;
  logic [CELL_W-1:0] res_data, res_data_next;
  logic              out_valid, out_valid_next;
  logic [CELL_W-1:0] out_cell_data, out_cell_data_next;
  logic [POS_W-1:0]  out_cursor, out_cursor_next;
  logic [CELL_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [POS_W-1:0]  cursor;

  assign cursor = POS_W'(row_start + POS_W'(col));

  always_comb begin
    state_next         = state;
    sweep_next         = sweep;
    pend_next          = 1'b0;
    pend_addr_next     = pend_addr;
    row_start_next     = row_start;
    col_next           = col;
    cmd_next           = cmd;
    res_data_next      = res_data;
    out_valid_next     = out_valid && rsp_stall;
    out_cell_data_next = out_cell_data;
    out_cursor_next    = out_cursor;
    q_pop              = 1'b0;
    mem_we             = 1'b0;
    mem_waddr          = sweep;
    mem_wdata          = BLANK_CELL;
    mem_raddr          = q_cmd.addr;
    unique case (state)
      ST_INIT: begin
        mem_we = 1'b1;
        if (sweep == LAST_ADDR) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end else begin
          sweep_next = ADDR_W'(sweep + 1'b1);
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          cmd_next      = q_cmd;
          res_data_next = '0;
          sweep_next    = '0;
          unique case (q_cmd.op)
            OP_PUT_CHAR: begin
              state_next = (cursor == POS_W'(CELL_COUNT)) ? ST_SCROLL : ST_WRITE;
            end
            OP_NEWLINE: begin
              if (row_start >= POS_W'(CELL_COUNT - COLUMNS)) begin
                state_next = ST_SCROLL;
              end else begin
                row_start_next = POS_W'(row_start + COLUMNS);
                col_next       = '0;
                state_next     = ST_DONE;
              end
            end
            OP_CLEAR: begin
              state_next = ST_CLEAR;
            end
            OP_READ: begin
              state_next = ST_READ;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_data_next = rd_data;
        state_next    = ST_DONE;
      end
      ST_SCROLL: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rd_data;
        end
        if (sweep < COPY_LEN) begin
          mem_raddr      = ADDR_W'(sweep + COLUMNS);
          pend_next      = 1'b1;
          pend_addr_next = sweep;
          sweep_next     = ADDR_W'(sweep + 1'b1);
        end else begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (sweep == LAST_ADDR) begin
          row_start_next = POS_W'(CELL_COUNT - COLUMNS);
          col_next       = '0;
          state_next     = (cmd.op == OP_PUT_CHAR) ? ST_WRITE : ST_DONE;
        end else begin
          sweep_next = ADDR_W'(sweep + 1'b1);
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(cursor);
        mem_wdata = {ATTR_WHITE, 1'b0, cmd.ch};
        if (col == COL_LAST) begin
          col_next       = '0;
          row_start_next = POS_W'(row_start + COLUMNS);
        end else begin
          col_next = COL_W'(col + 1'b1);
        end
        state_next = ST_DONE;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (sweep == LAST_ADDR) begin
          row_start_next = '0;
          col_next       = '0;
          state_next     = ST_DONE;
        end else begin
          sweep_next = ADDR_W'(sweep + 1'b1);
        end
      end
      ST_DONE: begin
        if (!out_valid || !rsp_stall) begin
          out_valid_next     = 1'b1;
          out_cell_data_next = res_data;
          out_cursor_next    = cursor;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      pend      <= 1'b0;
      row_start <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      pend      <= pend_next;
      row_start <= row_start_next;
      col       <= col_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr     <= pend_addr_next;
    cmd           <= cmd_next;
    res_data      <= res_data_next;
    out_cell_data <= out_cell_data_next;
    out_cursor    <= out_cursor_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  assign rsp_valid       = out_valid;
  assign cell_data       = out_cell_data;
  assign cursor_position = OUTP_W'(out_cursor);

  `TCSW_ASSERT_IMPLIES(a_cursor_range, 1'b1, cursor <= POS_W'(CELL_COUNT))
  `TCSW_ASSERT_IMPLIES(a_end_col, cursor == POS_W'(CELL_COUNT), col == '0)
  `TCSW_ASSERT_IMPLIES(a_copy_order, (state == ST_SCROLL) && pend, ADDR_W'(pend_addr + 1'b1) == sweep)
  `TCSW_ASSERT_NEXT(a_pop_leaves_idle, q_pop, state != ST_IDLE)
  `TCSW_ASSERT_NEXT(a_result_loads, (state == ST_DONE) && (!out_valid || !rsp_stall), out_valid)

endmodule

// ===== design/text_console_scroll_writer_core.sv =====
// Top level of the text console scroll writer.
`timescale 1ns / 1ps

// 80x25 text console: every command transaction (put character, clear,
// read cell) yields one response transaction with the read cell (zero
// unless a valid read) and the cursor after the command. Commands pass
// through a two-entry queue to a single-port-write cell store sequencer.
// After reset the store is blanked by a pass over every cell before the first
// command runs. A scroll (newline on the last row or a put at the end of the
// screen) copies 1920 cells one per cycle and blanks the bottom 80; a clear
// blanks every cell. The cell store takes one write per cycle.
module text_console_scroll_writer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [tcsw_pkg::MODE_W-1:0]   mode,
  input  logic [tcsw_pkg::CHAR_W-1:0]   character,
  input  logic [tcsw_pkg::IDX_W-1:0]    cell_index,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [tcsw_pkg::CELL_W-1:0]   cell_data,
  output logic [tcsw_pkg::OUTP_W-1:0]   cursor_position
);
  import tcsw_pkg::*;

  push_t q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  cmd_t  q_cmd;

  tcsw_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .mode       (mode),
    .character  (character),
    .cell_index (cell_index),
    .q_full     (q_full),
    .q_push     (q_push)
  );

  tcsw_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  tcsw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .cell_data       (cell_data),
    .cursor_position (cursor_position)
  );

endmodule
